@@ rtl/grc_pkg.sv @@
// Shared constants, types and the sine table builder of the grid ray caster.
// Depends on nothing; every other file imports it.
`default_nettype none
package grc_pkg;

    localparam int MAP_SIDE         = 64;
    localparam int MAP_BITS         = $clog2(MAP_SIDE);
    localparam int MAP_AW           = 2 * MAP_BITS;
    localparam int POS_FRAC_BITS    = 10;
    localparam int ANGLE_BITS       = 16;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int TAB_AW           = $clog2(SINE_TABLE_DEPTH);
    localparam int TRIG_BITS        = 14;
    localparam int DIV_W            = 40;
    localparam int DIV_CW           = $clog2(DIV_W + 1);
    localparam int SIDE_W           = 42;

    localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    typedef logic signed [15:0] sine_tab_t [SINE_TABLE_DEPTH];

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    function automatic sine_tab_t build_sine();
        sine_tab_t       tab;
        longint unsigned u, r, x, x2, term;
        longint          sum, v;
        int unsigned     quad;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            u    = (longint'(i) << 32) / SINE_TABLE_DEPTH;
            quad = int'((u >> 30) & 64'd3);
            r    = u & 64'h3FFF_FFFF;
            if (quad % 2 == 1) begin
                r = 64'h4000_0000 - r;
            end
            x    = (r * HALF_PI_Q30) >> 30;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 6; k++) begin
                term = (term * x2) >> 30;
                case (k)
                    1: term = term / 6;
                    2: term = term / 20;
                    3: term = term / 42;
                    4: term = term / 72;
                    5: term = term / 110;
                    default: term = term / 156;
                endcase
                if (k % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = (sum + 32768) >>> 16;
            if (v > 16384) begin
                v = 16384;
            end
            tab[i] = (quad >= 2) ? 16'(-v) : 16'(v);
        end
        return tab;
    endfunction

endpackage
`default_nettype wire

@@ rtl/grc_divider.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on grc_pkg for the operand width.
`default_nettype none
module grc_divider (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic [grc_pkg::DIV_W-1:0] dividend,
    input  wire logic [grc_pkg::DIV_W-1:0] divisor,
    output logic                         busy,
    output logic [grc_pkg::DIV_W-1:0]    quotient
);
    import grc_pkg::*;

    logic [DIV_W-1:0]  rem_reg, quo_reg, dvs_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic [DIV_W:0]    trial;

    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign busy     = busy_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CW'(DIV_W);
            rem_reg  <= '0;
            quo_reg  <= dividend;
            dvs_reg  <= divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_reg <= DIV_W'(trial - {1'b0, dvs_reg});
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_reg <= trial[DIV_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != DIV_CW'(1));
        end
    end
endmodule
`default_nettype wire

@@ rtl/grc_sine_rom.sv @@
// Sine table ROM with a registered read port.
// Depends on grc_pkg for the table builder.
`default_nettype none
module grc_sine_rom (
    input  wire logic                     aclk,
    input  wire logic [grc_pkg::TAB_AW-1:0] addr,
    output logic signed [15:0]            data
);
    import grc_pkg::*;

    localparam sine_tab_t SINE_TAB = build_sine();

    always_ff @(posedge aclk) begin
        data <= SINE_TAB[addr];
    end
endmodule
`default_nettype wire

@@ rtl/grc_wall_map.sv @@
// One-bit wall map memory, one write and one registered read port.
// Depends on grc_pkg for the address width.
`default_nettype none
module grc_wall_map (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [grc_pkg::MAP_AW-1:0] waddr,
    input  wire logic                     wdata,
    input  wire logic [grc_pkg::MAP_AW-1:0] raddr,
    output logic                          rdata
);
    import grc_pkg::*;

    logic mem [1 << MAP_AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/grid_raycast_wall_column.sv @@
// Top level of the grid ray caster: sequencer, registers and result stage.
// Depends on grc_pkg, grc_divider, grc_sine_rom and grc_wall_map.
//
// Channel  Dir  Contents
// s_       in   tuser: action; tdata: cell_col, cell_row, cell_is_wall, player_x,
//                player_y, view_angle, column
// m_       out  tuser: hit; tdata: column_out, wall_top, wall_bottom, shade, ray_length
// cfg_     in   register index and write data
//
// A cast runs up to seven divisions in the shared divider plus a border step and a map
// check for each cell border crossed.
// After reset all 4096 map cells are cleared before the first transfer.
// A finished result waits in the output register while the next item is taken.
`default_nettype none
module grid_raycast_wall_column (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic        s_tuser,   // action
    input  wire logic [71:0] s_tdata,   // cell_col, cell_row, cell_is_wall, player_x,
                                        // player_y, view_angle, column, zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic             m_tuser,   // hit
    output logic [71:0]      m_tdata,   // column_out, wall_top, wall_bottom, shade,
                                        // ray_length, zero pad
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);
    import grc_pkg::*;

    localparam logic [2:0] REG_COLS = 3'd0, REG_ROWS = 3'd1, REG_SPAN = 3'd2,
                           REG_RANGE = 3'd3, REG_SCALE = 3'd4, REG_GAIN = 3'd5,
                           REG_MCOLS = 3'd6, REG_MROWS = 3'd7;

    localparam logic [4:0] ST_CLEAR = 5'd0,  ST_IDLE = 5'd1,   ST_REL = 5'd2,
                           ST_WAIT = 5'd3,   ST_RELUSE = 5'd4, ST_ROM1 = 5'd5,
                           ST_ROM2 = 5'd6,   ST_ROM3 = 5'd7,   ST_ROM4 = 5'd8,
                           ST_AXS = 5'd9,    ST_AXD = 5'd10,   ST_AXE = 5'd11,
                           ST_AYS = 5'd12,   ST_AYD = 5'd13,   ST_AYE = 5'd14,
                           ST_LOOP = 5'd15,  ST_CHECK = 5'd16, ST_TMUL = 5'd17,
                           ST_TUSE = 5'd18,  ST_QSTART = 5'd19, ST_QUSE = 5'd20,
                           ST_SHMUL = 5'd21, ST_SHSTART = 5'd22, ST_SHUSE = 5'd23,
                           ST_FIN = 5'd24;

    localparam logic [SIDE_W-1:0] FAR_AWAY = SIDE_W'(1) << 40;
    localparam int PW = 16 + POS_FRAC_BITS - 9;

    // Configuration registers.
    logic [10:0] cols_reg, rows_reg;
    logic [14:0] span_reg;
    logic [15:0] range_reg, scale_reg;
    logic [9:0]  gain_reg;
    logic [6:0]  mcols_reg, mrows_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg  <= 11'd640;
            rows_reg  <= 11'd480;
            span_reg  <= 15'd10923;
            range_reg <= 16'd16384;
            scale_reg <= 16'd256;
            gain_reg  <= 10'd256;
            mcols_reg <= 7'd64;
            mrows_reg <= 7'd64;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_COLS:  cols_reg  <= cfg_wdata[10:0];
                REG_ROWS:  rows_reg  <= cfg_wdata[10:0];
                REG_SPAN:  span_reg  <= cfg_wdata[14:0];
                REG_RANGE: range_reg <= cfg_wdata;
                REG_SCALE: scale_reg <= cfg_wdata;
                REG_GAIN:  gain_reg  <= cfg_wdata[9:0];
                REG_MCOLS: mcols_reg <= cfg_wdata[6:0];
                REG_MROWS: mrows_reg <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // Input fields.
    logic [5:0]  in_col, in_row;
    logic        in_wall;
    logic [15:0] in_px, in_py, in_va;
    logic [9:0]  in_column;
    assign in_col    = s_tdata[5:0];
    assign in_row    = s_tdata[11:6];
    assign in_wall   = s_tdata[12];
    assign in_px     = s_tdata[28:13];
    assign in_py     = s_tdata[44:29];
    assign in_va     = s_tdata[60:45];
    assign in_column = s_tdata[70:61];

    logic [4:0]  state_reg, ret_reg;
    logic [MAP_AW-1:0] clr_reg;
    logic [PW-1:0] px_reg, py_reg;
    logic [15:0] va_reg, rel_reg, ray_reg;
    logic [9:0]  column_reg;
    logic signed [15:0] dirx_reg, diry_reg, cosrel_reg;
    logic signed [9:0] cx_reg, cy_reg;
    logic        negx_reg, negy_reg;
    logic [SIDE_W-1:0] sx_reg, sy_reg, dx_reg, dy_reg, dist_reg;
    logic [14:0] mag_reg;
    logic signed [43:0] tprod_reg;
    logic [26:0] t_reg;
    logic [33:0] shprod_reg;
    logic        hit_reg;
    logic [15:0] top_reg, bot_reg, len_reg;
    logic [7:0]  shade_reg;

    logic        out_valid_reg, out_hit_reg;
    logic [9:0]  out_col_reg;
    logic [15:0] out_top_reg, out_bot_reg, out_len_reg;
    logic [7:0]  out_shade_reg;

    // Divider, ROM and map connections.
    logic             div_start, div_busy;
    logic [DIV_W-1:0] div_a, div_b, div_q;
    logic [TAB_AW-1:0] rom_addr;
    logic signed [15:0] rom_q;
    logic             map_we, map_wdata, map_q;
    logic [MAP_AW-1:0] map_waddr, map_raddr;

    grc_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_a),
        .divisor(div_b), .busy(div_busy), .quotient(div_q)
    );
    grc_sine_rom u_rom (.aclk(aclk), .addr(rom_addr), .data(rom_q));
    grc_wall_map u_map (
        .aclk(aclk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
        .raddr(map_raddr), .rdata(map_q)
    );

    function automatic logic [15:0] sat16(input logic signed [22:0] v);
        if (v > 23'sd32767) begin
            return 16'h7FFF;
        end else if (v < -23'sd32768) begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    // Axis set-up helpers.
    logic [PW-1:0] apos, apos_m1;
    logic signed [15:0] adir;
    logic [10:0] af;
    logic signed [9:0] acell;
    logic [14:0] amag;
    logic [15:0] adir_neg;

    assign apos     = (state_reg == ST_AXS) ? px_reg : py_reg;
    assign adir     = (state_reg == ST_AXS) ? dirx_reg : diry_reg;
    assign apos_m1  = apos - 1'b1;
    assign adir_neg = 16'(-adir);

    always_comb begin
        if (adir < 0) begin
            acell = 10'(apos_m1[PW-1:POS_FRAC_BITS]);
            af    = {1'b0, apos_m1[POS_FRAC_BITS-1:0]} + 11'd1;
            amag  = adir_neg[14:0];
        end else begin
            acell = 10'(apos[PW-1:POS_FRAC_BITS]);
            af    = 11'd1024 - {1'b0, apos[POS_FRAC_BITS-1:0]};
            amag  = adir[14:0];
        end
    end

    // Border step.
    logic [SIDE_W-1:0] smin;
    logic signed [9:0] nx, ny;
    assign smin = (sx_reg < sy_reg) ? sx_reg : sy_reg;
    assign nx   = (sx_reg == smin) ? (negx_reg ? cx_reg - 10'sd1 : cx_reg + 10'sd1) : cx_reg;
    assign ny   = (sy_reg == smin) ? (negy_reg ? cy_reg - 10'sd1 : cy_reg + 10'sd1) : cy_reg;

    logic [6:0] mc, mr;
    logic       inside_map;
    assign mc = (mcols_reg > 7'(MAP_SIDE)) ? 7'(MAP_SIDE) : mcols_reg;
    assign mr = (mrows_reg > 7'(MAP_SIDE)) ? 7'(MAP_SIDE) : mrows_reg;
    assign inside_map = !cx_reg[9] && !cy_reg[9] && (cx_reg[8:0] < {2'b0, mc}) &&
                        (cy_reg[8:0] < {2'b0, mr});

    logic [20:0] qcap;
    logic signed [22:0] top_v, bot_v;
    logic [15:0] sh_diff;
    assign qcap    = (div_q > DIV_W'(1 << 20)) ? 21'(1 << 20) : div_q[20:0];
    assign top_v   = ($signed({12'b0, rows_reg}) - $signed({2'b0, qcap})) >>> 1;
    assign bot_v   = ($signed({12'b0, rows_reg}) + $signed({2'b0, qcap})) >>> 1;
    assign sh_diff = range_reg - dist_reg[15:0];

    logic accept;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        div_start = 1'b0;
        div_a     = '0;
        div_b     = '0;
        case (state_reg)
            ST_REL: begin
                div_start = 1'b1;
                div_a     = DIV_W'(column_reg * span_reg);
                div_b     = (cols_reg == 11'd0) ? DIV_W'(1) : DIV_W'(cols_reg);
            end
            ST_AXS, ST_AYS: begin
                div_start = (adir != 16'sd0);
                div_a     = DIV_W'({af, 14'b0});
                div_b     = DIV_W'(amag);
            end
            ST_AXD, ST_AYD: begin
                div_start = 1'b1;
                div_a     = DIV_W'(1) << (POS_FRAC_BITS + TRIG_BITS);
                div_b     = DIV_W'(mag_reg);
            end
            ST_QSTART: begin
                div_start = 1'b1;
                div_a     = DIV_W'({({16'b0, rows_reg} * {11'b0, scale_reg}), 10'b0});
                div_b     = DIV_W'({t_reg, 8'b0});
            end
            ST_SHSTART: begin
                div_start = 1'b1;
                div_a     = DIV_W'(shprod_reg);
                div_b     = DIV_W'({range_reg, 8'b0});
            end
            default: ;
        endcase
    end

    always_comb begin
        case (state_reg)
            ST_ROM1: rom_addr = TAB_AW'(16'(ray_reg + QUARTER_TURN) >> (ANGLE_BITS - TAB_AW));
            ST_ROM2: rom_addr = TAB_AW'(ray_reg >> (ANGLE_BITS - TAB_AW));
            default: rom_addr = TAB_AW'(16'(rel_reg + QUARTER_TURN) >> (ANGLE_BITS - TAB_AW));
        endcase
    end

    assign map_we    = (state_reg == ST_CLEAR) || (accept && !s_tuser);
    assign map_waddr = (state_reg == ST_CLEAR) ? clr_reg : {in_row, in_col};
    assign map_wdata = (state_reg == ST_CLEAR) ? 1'b0 : in_wall;
    assign map_raddr = {ny[MAP_BITS-1:0], nx[MAP_BITS-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            ret_reg   <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (&clr_reg) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept && s_tuser) begin
                        px_reg     <= PW'(in_px) + PW'(1 << (POS_FRAC_BITS - 1));
                        py_reg     <= PW'(in_py) + PW'(1 << (POS_FRAC_BITS - 1));
                        va_reg     <= in_va;
                        column_reg <= in_column;
                        state_reg  <= ST_REL;
                    end
                end
                ST_REL: begin
                    ret_reg   <= ST_RELUSE;
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (!div_busy) begin
                        state_reg <= ret_reg;
                    end
                end
                ST_RELUSE: begin
                    rel_reg   <= div_q[15:0] - {2'b0, span_reg[14:1]};
                    ray_reg   <= va_reg + div_q[15:0] - {2'b0, span_reg[14:1]};
                    state_reg <= ST_ROM1;
                end
                ST_ROM1: state_reg <= ST_ROM2;
                ST_ROM2: begin
                    dirx_reg  <= rom_q;
                    state_reg <= ST_ROM3;
                end
                ST_ROM3: begin
                    diry_reg  <= rom_q;
                    state_reg <= ST_ROM4;
                end
                ST_ROM4: begin
                    cosrel_reg <= rom_q;
                    state_reg  <= ST_AXS;
                end
                ST_AXS: begin
                    cx_reg   <= acell;
                    negx_reg <= (adir < 0);
                    mag_reg  <= amag;
                    if (adir == 16'sd0) begin
                        sx_reg    <= FAR_AWAY;
                        dx_reg    <= FAR_AWAY;
                        state_reg <= ST_AYS;
                    end else begin
                        ret_reg   <= ST_AXD;
                        state_reg <= ST_WAIT;
                    end
                end
                ST_AXD: begin
                    sx_reg    <= SIDE_W'(div_q);
                    ret_reg   <= ST_AXE;
                    state_reg <= ST_WAIT;
                end
                ST_AXE: begin
                    dx_reg    <= SIDE_W'(div_q);
                    state_reg <= ST_AYS;
                end
                ST_AYS: begin
                    cy_reg   <= acell;
                    negy_reg <= (adir < 0);
                    mag_reg  <= amag;
                    dist_reg <= '0;
                    if (adir == 16'sd0) begin
                        sy_reg    <= FAR_AWAY;
                        dy_reg    <= FAR_AWAY;
                        state_reg <= ST_LOOP;
                    end else begin
                        ret_reg   <= ST_AYD;
                        state_reg <= ST_WAIT;
                    end
                end
                ST_AYD: begin
                    sy_reg    <= SIDE_W'(div_q);
                    ret_reg   <= ST_AYE;
                    state_reg <= ST_WAIT;
                end
                ST_AYE: begin
                    dy_reg    <= SIDE_W'(div_q);
                    state_reg <= ST_LOOP;
                end
                ST_LOOP: begin
                    if (dist_reg < SIDE_W'(range_reg)) begin
                        cx_reg    <= nx;
                        cy_reg    <= ny;
                        if (sx_reg == smin) begin
                            sx_reg <= sx_reg + dx_reg;
                        end
                        if (sy_reg == smin) begin
                            sy_reg <= sy_reg + dy_reg;
                        end
                        dist_reg  <= smin;
                        state_reg <= ST_CHECK;
                    end else begin
                        hit_reg   <= 1'b0;
                        top_reg   <= '0;
                        bot_reg   <= '0;
                        shade_reg <= '0;
                        len_reg   <= '0;
                        state_reg <= ST_FIN;
                    end
                end
                ST_CHECK: begin
                    if (inside_map && map_q) begin
                        hit_reg   <= 1'b1;
                        len_reg   <= (dist_reg > SIDE_W'(16'hFFFF)) ? 16'hFFFF
                                                                    : dist_reg[15:0];
                        state_reg <= ST_TMUL;
                    end else begin
                        state_reg <= ST_LOOP;
                    end
                end
                ST_TMUL: begin
                    tprod_reg <= $signed({1'b0, dist_reg[26:0]}) * cosrel_reg;
                    state_reg <= ST_TUSE;
                end
                ST_TUSE: begin
                    if ((tprod_reg >>> TRIG_BITS) < 44'sd1) begin
                        t_reg <= 27'd1;
                    end else begin
                        t_reg <= tprod_reg[TRIG_BITS+26:TRIG_BITS];
                    end
                    state_reg <= ST_QSTART;
                end
                ST_QSTART: begin
                    ret_reg   <= ST_QUSE;
                    state_reg <= ST_WAIT;
                end
                ST_QUSE: begin
                    top_reg <= sat16(top_v);
                    bot_reg <= sat16(bot_v);
                    if (dist_reg < SIDE_W'(range_reg)) begin
                        state_reg <= ST_SHMUL;
                    end else begin
                        shade_reg <= '0;
                        state_reg <= ST_FIN;
                    end
                end
                ST_SHMUL: begin
                    shprod_reg <= 34'(({sh_diff, 8'b0} - 24'(sh_diff)) * gain_reg);
                    state_reg  <= ST_SHSTART;
                end
                ST_SHSTART: begin
                    ret_reg   <= ST_SHUSE;
                    state_reg <= ST_WAIT;
                end
                ST_SHUSE: begin
                    shade_reg <= (div_q > DIV_W'(255)) ? 8'd255 : div_q[7:0];
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (!out_valid_reg || m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (state_reg == ST_FIN && (!out_valid_reg || m_tready)) begin
            out_valid_reg <= 1'b1;
            out_hit_reg   <= hit_reg;
            out_col_reg   <= column_reg;
            out_top_reg   <= top_reg;
            out_bot_reg   <= bot_reg;
            out_shade_reg <= shade_reg;
            out_len_reg   <= len_reg;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = {6'b0, out_len_reg, out_shade_reg, out_bot_reg, out_top_reg,
                       out_col_reg};

    a_idle_divider: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_busy) else $error("input taken while the divider runs");
    a_check_after_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) |-> ($past(state_reg) == ST_LOOP))
        else $error("map check without a border step");
    a_hit_has_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[65:50] != 16'd0))
        else $error("hit reported with zero ray length");
endmodule
`default_nettype wire

@@ bench/grid_raycast_wall_column_tb.sv @@
// Self-checking testbench of grid_raycast_wall_column: map writes and column casts are
// streamed in under random idling, and every result is checked against a ray walker
// kept in this file. Depends on grc_pkg and the grid_raycast_wall_column RTL.
`default_nettype none
module grid_raycast_wall_column_tb;
    import grc_pkg::*;

    typedef enum logic {ACT_WRITE = 1'b0, ACT_CAST = 1'b1} act_e;
    typedef enum logic [2:0] {
        REG_COLUMNS = 3'd0, REG_ROWS = 3'd1, REG_SPAN = 3'd2, REG_RANGE = 3'd3,
        REG_SCALE = 3'd4, REG_GAIN = 3'd5, REG_MAP_COLS = 3'd6, REG_MAP_ROWS = 3'd7
    } reg_e;

    typedef struct {
        logic               hit;
        logic [9:0]         col;
        logic signed [15:0] top;
        logic signed [15:0] bottom;
        logic [7:0]         shade;
        logic [15:0]        length;
    } column_t;

    localparam longint FAR_OFF    = longint'(1) << 40;
    localparam longint CELL       = longint'(1) << POS_FRAC_BITS;
    localparam int     QUIET_MAX  = 20000;

    logic        aclk, aresetn;
    logic        s_tvalid, s_tuser, m_tready, m_tvalid, m_tuser;
    logic        s_tready;
    logic [71:0] s_tdata, m_tdata;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wdata;

    grid_raycast_wall_column uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // Shadow state of the block.
    logic signed [15:0] sin_rom [SINE_TABLE_DEPTH];
    bit          wall_cells [MAP_SIDE*MAP_SIDE];
    int unsigned n_cols, n_rows, span, range_lim, scale, gain, m_cols, m_rows;

    column_t     pending_columns[$];
    int          errors, casts_sent, writes_sent, columns_seen, hits_seen;
    int          quiet_cycles;
    bit          no_idle;
    int          hold_off;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void fill_sine();
        longint unsigned u, r, x, x2, term;
        longint          acc, v;
        int unsigned     quad;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            u    = (longint'(i) << 32) / SINE_TABLE_DEPTH;
            quad = int'(u >> 30) & 3;
            r    = u & 64'h3FFF_FFFF;
            if (quad[0]) r = 64'h4000_0000 - r;
            x    = (r * 64'd1686629713) >> 30;
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            for (int k = 1; k <= 6; k++) begin
                term = (term * x2) >> 30;
                term = term / longint'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) acc -= longint'(term);
                else acc += longint'(term);
            end
            if (acc < 0) acc = 0;
            v = (acc + 32768) >>> 16;
            if (v > 16384) v = 16384;
            sin_rom[i] = (quad >= 2) ? 16'(-v) : 16'(v);
        end
    endfunction

    function automatic longint sin_at(longint a);
        return longint'(sin_rom[((a & 65535) * SINE_TABLE_DEPTH) >> ANGLE_BITS]);
    endfunction

    function automatic void border_init(input longint pos, input longint dir,
                                        output longint cidx, output longint side,
                                        output longint dlt, output longint stp);
        longint frac;
        if (dir == 0) begin
            cidx = pos >>> POS_FRAC_BITS;
            side = FAR_OFF; dlt = FAR_OFF; stp = 0;
            return;
        end
        if (dir > 0) begin
            cidx = pos >>> POS_FRAC_BITS;
            frac = CELL - (pos - cidx * CELL);
            stp  = 1;
        end else begin
            cidx = (pos - 1) >>> POS_FRAC_BITS;
            frac = pos - cidx * CELL;
            stp  = -1;
            dir  = -dir;
        end
        side = (frac * 16384) / dir;
        dlt  = (CELL * 16384) / dir;
    endfunction

    function automatic longint sat_row(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint floor_half(longint v);
        return v < 0 ? (v - 1) / 2 : v / 2;
    endfunction

    function automatic column_t cast_column(longint px, longint py, longint heading,
                                            longint col);
        column_t res;
        longint  cols, rel, ray, cx, sx, dx, tx, cy, sy, dy, ty, walked, s, mc, mr;
        longint  lim, t, h, q, shd;
        bit      hit;
        px      = px & 65535;
        py      = py & 65535;
        heading = heading & 65535;
        col     = col & 1023;
        cols = n_cols ? n_cols : 1;
        mc   = m_cols > MAP_SIDE ? MAP_SIDE : m_cols;
        mr   = m_rows > MAP_SIDE ? MAP_SIDE : m_rows;
        lim  = range_lim;
        rel  = (col * span) / cols - (span >> 1);
        ray  = (heading + rel) & 65535;
        border_init(px + CELL / 2, sin_at(ray + 16384), cx, sx, dx, tx);
        border_init(py + CELL / 2, sin_at(ray), cy, sy, dy, ty);
        hit    = 1'b0;
        walked = 0;
        while (!hit && walked < lim) begin
            s = sx < sy ? sx : sy;
            if (sx == s) begin cx += tx; sx += dx; end
            if (sy == s) begin cy += ty; sy += dy; end
            walked = s;
            if (cx >= 0 && cx < mc && cy >= 0 && cy < mr)
                hit = wall_cells[cy * MAP_SIDE + cx];
        end
        res = '{hit: hit, col: col[9:0], top: '0, bottom: '0, shade: '0, length: '0};
        if (!hit) return res;
        t = (walked * sin_at(rel + 16384)) / 16384;
        if (t < 1) t = 1;
        h = n_rows;
        q = ((h * scale) << POS_FRAC_BITS) / (t * 256);
        if (q > (longint'(1) << 20)) q = longint'(1) << 20;
        shd = 0;
        if (walked < lim) begin
            shd = (255 * (lim - walked) * gain) / (lim * 256);
            if (shd > 255) shd = 255;
        end
        res.top    = 16'(sat_row(floor_half(h - q)));
        res.bottom = 16'(sat_row(floor_half(h + q)));
        res.shade  = 8'(shd);
        res.length = walked > 65535 ? 16'hFFFF : 16'(walked);
        return res;
    endfunction

    task automatic set_reg(reg_e idx, int unsigned value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= 16'(value);
        case (idx)
            REG_COLUMNS:  n_cols    = value & 16'h7FF;
            REG_ROWS:     n_rows    = value & 16'h7FF;
            REG_SPAN:     span      = value & 16'h7FFF;
            REG_RANGE:    range_lim = value & 16'hFFFF;
            REG_SCALE:    scale     = value & 16'hFFFF;
            REG_GAIN:     gain      = value & 16'h3FF;
            REG_MAP_COLS: m_cols    = value & 16'h7F;
            default:      m_rows    = value & 16'h7F;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_item(act_e act, int cc, int cr, bit wall, int px, int py, int hd,
                             int col);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {1'b0, 10'(col), 16'(hd), 16'(py), 16'(px), wall, 6'(cr), 6'(cc)};
        do @(posedge aclk); while (!s_tready);
        if (act == ACT_WRITE) begin
            wall_cells[cr * MAP_SIDE + cc] = wall;
            writes_sent++;
        end else begin
            pending_columns.push_back(cast_column(px, py, hd, col));
            casts_sent++;
        end
    endtask

    task automatic cast(int px, int py, int hd, int col);
        send_item(ACT_CAST, 0, 0, 1'b0, px, py, hd, col);
    endtask

    task automatic write_cell(int cc, int cr, bit wall);
        send_item(ACT_WRITE, cc, cr, wall, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_columns.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // Result side: random ready gaps, a long hold-off on request, and the checker.
    initial begin
        int     gap;
        column_t exp_col;
        gap = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                columns_seen++;
                if (pending_columns.size() == 0) begin
                    $display("%0t: unexpected transfer, actual hit=%0b data=%h", $time,
                             m_tuser, m_tdata);
                    errors++;
                end else begin
                    exp_col = pending_columns.pop_front();
                    if (m_tuser) hits_seen++;
                    if (m_tuser !== exp_col.hit ||
                        m_tdata[9:0] !== exp_col.col ||
                        m_tdata[25:10] !== exp_col.top ||
                        m_tdata[41:26] !== exp_col.bottom ||
                        m_tdata[49:42] !== exp_col.shade ||
                        m_tdata[65:50] !== exp_col.length ||
                        m_tdata[71:66] !== '0) begin
                        $display({"%0t: mismatch expected hit=%0b col=%0d top=%0d ",
                                  "bot=%0d shade=%0d len=%0d"},
                                 $time, exp_col.hit, exp_col.col, exp_col.top,
                                 exp_col.bottom, exp_col.shade, exp_col.length);
                        $display({"%0t:          actual hit=%0b col=%0d top=%0d ",
                                  "bot=%0d shade=%0d len=%0d pad=%h"},
                                 $time, m_tuser, m_tdata[9:0],
                                 $signed(m_tdata[25:10]), $signed(m_tdata[41:26]),
                                 m_tdata[49:42], m_tdata[65:50], m_tdata[71:66]);
                        errors++;
                    end
                end
                gap = no_idle ? 0 : $urandom_range(0, 6);
            end
            if (hold_off > 0) begin
                hold_off--;
                m_tready <= 1'b0;
            end else if (gap > 0) begin
                gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any transfer.
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_MAX) begin
                $display("%0t: no transfer for %0d cycles", $time, QUIET_MAX);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic test_directed();
        // A wall row at cell row 8 near cell (10,10) and single walls on the axes.
        for (int i = 8; i <= 12; i++) write_cell(i, 8, 1'b1);
        write_cell(12, 10, 1'b1);
        write_cell(10, 12, 1'b1);
        write_cell(11, 12, 1'b0);
        write_cell(63, 63, 1'b1);
        cast(10 * 1024, 10 * 1024, 0, 320);         // ray along +x
        cast(10 * 1024, 10 * 1024, 16384, 320);     // ray along +y
        cast(10 * 1024, 10 * 1024, 49152, 320);     // ray along -y
        cast(10 * 1024, 10 * 1024, 8192, 320);      // diagonal, both borders together
        cast(11 * 1024 + 1000, 10 * 1024, 0, 320);  // player inside the wall cell (12,10)
        cast(10 * 1024, 10 * 1024, 32768, 0);       // leftmost column, open side
        cast(10 * 1024, 10 * 1024, 65535, 1023);    // column beyond the screen
        cast(0, 0, 8192, 639);
        cast(65535, 65535, 40960, 320);
        cast(62 * 1024, 62 * 1024, 8192, 320);
    endtask

    task automatic test_backpressure();
        // Hold the result side for a long stretch while casts keep coming.
        hold_off = 2000;
        for (int i = 0; i < 6; i++)
            cast(10 * 1024, 10 * 1024, $urandom, $urandom_range(0, 639));
        drain();
    endtask

    task automatic test_random_phase(int items, int density);
        for (int i = 0; i < items; i++) begin
            if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 25)
                write_cell($urandom_range(0, 63), $urandom_range(0, 63),
                           $urandom_range(0, 99) < density);
            else if ($urandom_range(0, 9) == 0)
                cast($urandom, $urandom, $urandom, $urandom);
            else
                cast($urandom_range(0, m_cols * 1024 + 2047),
                     $urandom_range(0, m_rows * 1024 + 2047),
                     $urandom, $urandom_range(0, 1023));
        end
        no_idle = 1'b0;
        drain();
    endtask

    task automatic test_settings();
        // Extremes of every register, then random mid values.
        set_reg(REG_COLUMNS, 0);    set_reg(REG_ROWS, 1);
        set_reg(REG_SPAN, 32767);   set_reg(REG_RANGE, 65535);
        set_reg(REG_SCALE, 65535);  set_reg(REG_GAIN, 1023);
        set_reg(REG_MAP_COLS, 127); set_reg(REG_MAP_ROWS, 1);
        test_random_phase(150, 30);
        set_reg(REG_COLUMNS, 2047); set_reg(REG_ROWS, 2047);
        set_reg(REG_SPAN, 1);       set_reg(REG_RANGE, 1);
        set_reg(REG_SCALE, 1);      set_reg(REG_GAIN, 0);
        set_reg(REG_MAP_COLS, 1);   set_reg(REG_MAP_ROWS, 64);
        test_random_phase(100, 30);
        set_reg(REG_COLUMNS, 1024); set_reg(REG_ROWS, 1024);
        set_reg(REG_RANGE, 3000);   set_reg(REG_MAP_COLS, 0);
        set_reg(REG_MAP_ROWS, 127); set_reg(REG_GAIN, 700);
        test_random_phase(100, 40);
        set_reg(REG_COLUMNS, $urandom_range(1, 1024));
        set_reg(REG_ROWS, $urandom_range(1, 1024));
        set_reg(REG_SPAN, $urandom_range(1, 32767));
        set_reg(REG_RANGE, $urandom_range(1000, 40000));
        set_reg(REG_SCALE, $urandom_range(1, 2000));
        set_reg(REG_GAIN, $urandom_range(0, 1023));
        set_reg(REG_MAP_COLS, 64);
        set_reg(REG_MAP_ROWS, 64);
        test_random_phase(250, 25);
    endtask

    initial begin
        int waited;
        aresetn = 1'b0; s_tvalid = 1'b0; s_tuser = 1'b0; s_tdata = '0;
        cfg_wr_en = 1'b0; cfg_index = '0; cfg_wdata = '0;
        errors = 0; casts_sent = 0; writes_sent = 0; columns_seen = 0; hits_seen = 0;
        no_idle = 1'b0; hold_off = 0;
        fill_sine();
        foreach (wall_cells[i]) wall_cells[i] = 1'b0;
        n_cols = 640; n_rows = 480; span = 10923; range_lim = 16384;
        scale = 256; gain = 256; m_cols = 64; m_rows = 64;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_backpressure();
        test_random_phase(400, 20);
        test_settings();

        waited = 0;
        while (pending_columns.size() != 0 && waited < QUIET_MAX) begin
            @(posedge aclk);
            waited++;
        end
        repeat (300) @(posedge aclk);
        $display("Sent %0d casts and %0d map writes; checked %0d columns, %0d of them hits.",
                 casts_sent, writes_sent, columns_seen, hits_seen);
        $display("Covered register extremes, axis and diagonal rays and a long output stall.");
        if (errors == 0 && pending_columns.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d columns still outstanding", errors,
                     pending_columns.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire
